### rtl/ulc_pkg.sv
package ulc_pkg;

   // Angle and sine table geometry
   localparam int ANGLE_BITS       = 16;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int QSH              = ANGLE_BITS - 2;                 // phase bits
   localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);  // 0..DEPTH
   localparam int IDXP_W           = QSH + IDX_W;
   localparam int ANG_EXT_W        = 16 + ANGLE_BITS;
   localparam int ROM_W            = 15;                             // 0..16384
   localparam int TRIG_W           = ROM_W + 1;                      // signed Q2.14

   // Datapath widths
   localparam int DIFF_W   = 17;
   localparam int GPROD_W  = 34;                  // gain * difference
   localparam int RATE_W   = GPROD_W + 1 - 12;    // after round by 12
   localparam int V_W      = RATE_W + 1;          // virtual control
   localparam int TPROD_W  = V_W + TRIG_W;        // trig * v
   localparam int TSUM_W   = TPROD_W + 1;
   localparam int LIN_W    = TSUM_W + 1 - 14;     // after round by 14
   localparam int RPROD_W  = LIN_W + 17;          // t * reciprocal
   localparam int TURN_W   = RPROD_W + 1 - 10;    // after round by 10
   localparam int SAT_IN_W = TURN_W;

   // Mid queue, depth is a power of two
   localparam int MQ_DEPTH = 4;
   localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
   localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int PADDR_W    = 4;
   localparam int REG_IDX_W  = PADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_X     = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_GAIN_Y     = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_RECIP_OFFS = REG_IDX_W'(2);
   localparam logic [15:0] GAIN_RESET  = 16'd4096;
   localparam logic [15:0] RECIP_RESET = 16'd1024;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [15:0] ref_x;
      logic signed [15:0] ref_y;
      logic signed [15:0] model_x;
      logic signed [15:0] model_y;
      logic signed [15:0] meas_x;
      logic signed [15:0] meas_y;
      logic [15:0]        heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] linear_speed;
      logic signed [15:0] turn_rate;
      logic signed [15:0] model_rate_x;
      logic signed [15:0] model_rate_y;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [15:0] gain_x;
      logic [15:0] gain_y;
      logic [15:0] reciprocal_offset;
   } cfg_type;

   // Word handed from the front part to the back part
   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [V_W-1:0]    v1;
      logic signed [V_W-1:0]    v2;
      logic signed [TRIG_W-1:0] sine_val;
      logic signed [TRIG_W-1:0] cosine_val;
   } mid_type;

   typedef struct packed {
      logic               clip;
      logic signed [15:0] value;
   } sat_type;

   typedef logic [ROM_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // Quarter-wave table, Q30 Taylor series, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          val;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x = (HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
         x2 = (x * x) >> 30;
         term = x;
         sum = signed'(x);
         for (int k = 1; k <= 10; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         val = (sum * 16384 + (64'sd1 <<< 29)) >>> 30;
         if (val > 16384) begin
            val = 16384;
         end
         rom[i] = ROM_W'(val);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(32767);
   localparam logic signed [SAT_IN_W-1:0] SAT_MIN = SAT_IN_W'(-32768);

   function automatic sat_type sat16(input logic signed [SAT_IN_W-1:0] x);
      sat_type r;
      r.clip  = 1'b0;
      r.value = x[15:0];
      if (x > SAT_MAX) begin
         r.clip  = 1'b1;
         r.value = 16'sh7fff;
      end else if (x < SAT_MIN) begin
         r.clip  = 1'b1;
         r.value = 16'sh8000;
      end
      return r;
   endfunction

endpackage

### rtl/ulc_front.sv
module ulc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ulc_pkg::req_type  in_word,
   input  ulc_pkg::cfg_type  cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output ulc_pkg::mid_type  out_word
);

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef struct packed {
      logic signed [ulc_pkg::DIFF_W-1:0] d_rm_x;   // ref - model
      logic signed [ulc_pkg::DIFF_W-1:0] d_mm_x;   // model - meas
      logic signed [ulc_pkg::DIFF_W-1:0] d_rm_y;
      logic signed [ulc_pkg::DIFF_W-1:0] d_mm_y;
      logic [1:0]                        quad;
      logic [ulc_pkg::IDX_W-1:0]         idx_a;
      logic [ulc_pkg::IDX_W-1:0]         idx_b;
   } f1_type;

   typedef struct packed {
      logic signed [ulc_pkg::GPROD_W-1:0] p_rm_x;
      logic signed [ulc_pkg::GPROD_W-1:0] p_mm_x;
      logic signed [ulc_pkg::GPROD_W-1:0] p_rm_y;
      logic signed [ulc_pkg::GPROD_W-1:0] p_mm_y;
      logic signed [ulc_pkg::TRIG_W-1:0]  sine_val;
      logic signed [ulc_pkg::TRIG_W-1:0]  cosine_val;
   } f2_type;

   function automatic logic signed [ulc_pkg::RATE_W-1:0] rnd12(
      input logic signed [ulc_pkg::GPROD_W-1:0] p);
      logic signed [ulc_pkg::GPROD_W:0] tmp;
      tmp = (ulc_pkg::GPROD_W + 1)'(p) + (ulc_pkg::GPROD_W + 1)'(2048);
      return tmp[ulc_pkg::GPROD_W:12];
   endfunction

   f1_type           f1_in, f1_ff;
   f2_type           f2_in, f2_ff;
   ulc_pkg::mid_type f3_in, f3_ff;
   logic f1_valid_in, f1_valid_ff;
   logic f2_valid_in, f2_valid_ff;
   logic f3_valid_in, f3_valid_ff;
   logic f1_ready, f2_ready, f3_ready;

   logic [ulc_pkg::ANG_EXT_W-1:0]  ang_ext;
   logic [ulc_pkg::ANGLE_BITS-1:0] ang;
   logic [ulc_pkg::IDXP_W-1:0]     idx_prod;
   logic [ulc_pkg::IDXP_W-1:0]     idx_sh;
   logic [ulc_pkg::IDX_W-1:0]      idx;
   logic signed [ulc_pkg::TRIG_W-1:0] tab_a, tab_b;
   logic signed [16:0] gx_s, gy_s;
   logic signed [ulc_pkg::RATE_W-1:0] r_mm_x, r_mm_y;

   assign f3_ready = !f3_valid_ff || out_ready;
   assign f2_ready = !f2_valid_ff || f3_ready;
   assign f1_ready = !f1_valid_ff || f2_ready;
   assign in_ready = f1_ready;

   assign f1_valid_in = in_valid;
   assign f2_valid_in = f1_valid_ff;
   assign f3_valid_in = f2_valid_ff;

   // Stage 1: differences, quadrant and table index
   always_comb begin
      ang_ext  = {in_word.heading, ulc_pkg::ANGLE_BITS'(0)};
      ang      = ang_ext[ulc_pkg::ANG_EXT_W-1 -: ulc_pkg::ANGLE_BITS];
      idx_prod = ulc_pkg::IDXP_W'(ang[ulc_pkg::QSH-1:0])
                 * ulc_pkg::IDXP_W'(ulc_pkg::SINE_TABLE_DEPTH)
                 + (ulc_pkg::IDXP_W'(1) << (ulc_pkg::QSH - 1));
      idx_sh   = idx_prod >> ulc_pkg::QSH;
      if (idx_sh > ulc_pkg::IDXP_W'(ulc_pkg::SINE_TABLE_DEPTH)) begin
         idx = ulc_pkg::IDX_W'(ulc_pkg::SINE_TABLE_DEPTH);
      end else begin
         idx = idx_sh[ulc_pkg::IDX_W-1:0];
      end
      f1_in.quad   = ang[ulc_pkg::ANGLE_BITS-1 -: 2];
      f1_in.idx_a  = idx;
      f1_in.idx_b  = ulc_pkg::IDX_W'(ulc_pkg::SINE_TABLE_DEPTH) - idx;
      f1_in.d_rm_x = ulc_pkg::DIFF_W'(in_word.ref_x) - ulc_pkg::DIFF_W'(in_word.model_x);
      f1_in.d_mm_x = ulc_pkg::DIFF_W'(in_word.model_x) - ulc_pkg::DIFF_W'(in_word.meas_x);
      f1_in.d_rm_y = ulc_pkg::DIFF_W'(in_word.ref_y) - ulc_pkg::DIFF_W'(in_word.model_y);
      f1_in.d_mm_y = ulc_pkg::DIFF_W'(in_word.model_y) - ulc_pkg::DIFF_W'(in_word.meas_y);
   end

   // Stage 2: gain products, sine table reads, quadrant fold
   always_comb begin
      gx_s  = signed'({1'b0, cfg.gain_x});
      gy_s  = signed'({1'b0, cfg.gain_y});
      tab_a = ulc_pkg::TRIG_W'(ulc_pkg::SINE_ROM[f1_ff.idx_a]);
      tab_b = ulc_pkg::TRIG_W'(ulc_pkg::SINE_ROM[f1_ff.idx_b]);
      f2_in.p_rm_x = f1_ff.d_rm_x * gx_s;
      f2_in.p_mm_x = f1_ff.d_mm_x * gx_s;
      f2_in.p_rm_y = f1_ff.d_rm_y * gy_s;
      f2_in.p_mm_y = f1_ff.d_mm_y * gy_s;
      case (f1_ff.quad)
         QUAD_FIRST: begin
            f2_in.sine_val   = tab_a;
            f2_in.cosine_val = tab_b;
         end
         QUAD_SECOND: begin
            f2_in.sine_val   = tab_b;
            f2_in.cosine_val = -tab_a;
         end
         QUAD_THIRD: begin
            f2_in.sine_val   = -tab_a;
            f2_in.cosine_val = -tab_b;
         end
         QUAD_FOURTH: begin
            f2_in.sine_val   = -tab_b;
            f2_in.cosine_val = tab_a;
         end
         default: begin
            f2_in.sine_val   = tab_a;
            f2_in.cosine_val = tab_b;
         end
      endcase
   end

   // Stage 3: round, model rate and virtual control
   always_comb begin
      f3_in.rate_x     = rnd12(f2_ff.p_rm_x);
      f3_in.rate_y     = rnd12(f2_ff.p_rm_y);
      r_mm_x           = rnd12(f2_ff.p_mm_x);
      r_mm_y           = rnd12(f2_ff.p_mm_y);
      f3_in.v1         = ulc_pkg::V_W'(f3_in.rate_x) + ulc_pkg::V_W'(r_mm_x);
      f3_in.v2         = ulc_pkg::V_W'(f3_in.rate_y) + ulc_pkg::V_W'(r_mm_y);
      f3_in.sine_val   = f2_ff.sine_val;
      f3_in.cosine_val = f2_ff.cosine_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         if (f1_ready) begin
            f1_valid_ff <= f1_valid_in;
         end
         if (f2_ready) begin
            f2_valid_ff <= f2_valid_in;
         end
         if (f3_ready) begin
            f3_valid_ff <= f3_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f1_ready) begin
         f1_ff <= f1_in;
      end
      if (f2_ready) begin
         f2_ff <= f2_in;
      end
      if (f3_ready) begin
         f3_ff <= f3_in;
      end
   end

   assign out_valid = f3_valid_ff;
   assign out_word  = f3_ff;

endmodule

### rtl/ulc_mid_queue.sv
module ulc_mid_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ulc_pkg::mid_type push_word,
   input  logic             pop,
   output logic             empty,
   output ulc_pkg::mid_type pop_word
);

   ulc_pkg::mid_type slot_ff [ulc_pkg::MQ_DEPTH];
   ulc_pkg::mid_type slot_in;
   logic [ulc_pkg::MQ_PTR_W-1:0] wr_ptr_in, wr_ptr_ff;
   logic [ulc_pkg::MQ_PTR_W-1:0] rd_ptr_in, rd_ptr_ff;
   logic [ulc_pkg::MQ_CNT_W-1:0] count_in, count_ff;
   logic do_push, do_pop;

   assign full    = count_ff == ulc_pkg::MQ_CNT_W'(ulc_pkg::MQ_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign slot_in   = push_word;
   assign wr_ptr_in = do_push ? wr_ptr_ff + ulc_pkg::MQ_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + ulc_pkg::MQ_PTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + ulc_pkg::MQ_CNT_W'(do_push) - ulc_pkg::MQ_CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign pop_word = slot_ff[rd_ptr_ff];

endmodule

### rtl/ulc_back.sv
module ulc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ulc_pkg::mid_type in_word,
   input  ulc_pkg::cfg_type cfg,
   output logic             out_valid,
   input  logic             out_ready,
   output ulc_pkg::rsp_type out_word
);

   typedef struct packed {
      logic signed [ulc_pkg::TPROD_W-1:0] p_cv1;
      logic signed [ulc_pkg::TPROD_W-1:0] p_sv2;
      logic signed [ulc_pkg::TPROD_W-1:0] p_cv2;
      logic signed [ulc_pkg::TPROD_W-1:0] p_sv1;
      logic signed [ulc_pkg::RATE_W-1:0]  rate_x;
      logic signed [ulc_pkg::RATE_W-1:0]  rate_y;
   } b1_type;

   typedef struct packed {
      logic signed [ulc_pkg::LIN_W-1:0]  lin;
      logic signed [ulc_pkg::LIN_W-1:0]  t;
      logic signed [ulc_pkg::RATE_W-1:0] rate_x;
      logic signed [ulc_pkg::RATE_W-1:0] rate_y;
   } b2_type;

   typedef struct packed {
      logic signed [ulc_pkg::LIN_W-1:0]   lin;
      logic signed [ulc_pkg::RPROD_W-1:0] p_turn;
      logic signed [ulc_pkg::RATE_W-1:0]  rate_x;
      logic signed [ulc_pkg::RATE_W-1:0]  rate_y;
   } b3_type;

   function automatic logic signed [ulc_pkg::LIN_W-1:0] rnd14(
      input logic signed [ulc_pkg::TSUM_W-1:0] x);
      logic signed [ulc_pkg::TSUM_W:0] tmp;
      tmp = (ulc_pkg::TSUM_W + 1)'(x) + (ulc_pkg::TSUM_W + 1)'(8192);
      return tmp[ulc_pkg::TSUM_W:14];
   endfunction

   function automatic logic signed [ulc_pkg::TURN_W-1:0] rnd10(
      input logic signed [ulc_pkg::RPROD_W-1:0] x);
      logic signed [ulc_pkg::RPROD_W:0] tmp;
      tmp = (ulc_pkg::RPROD_W + 1)'(x) + (ulc_pkg::RPROD_W + 1)'(512);
      return tmp[ulc_pkg::RPROD_W:10];
   endfunction

   b1_type           b1_in, b1_ff;
   b2_type           b2_in, b2_ff;
   b3_type           b3_in, b3_ff;
   ulc_pkg::rsp_type b4_in, b4_ff;
   logic b1_valid_in, b1_valid_ff;
   logic b2_valid_in, b2_valid_ff;
   logic b3_valid_in, b3_valid_ff;
   logic b4_valid_in, b4_valid_ff;
   logic b1_ready, b2_ready, b3_ready, b4_ready;

   logic signed [ulc_pkg::TSUM_W-1:0] sum_lin, sum_turn;
   logic signed [16:0]                recip_s;
   logic signed [ulc_pkg::TURN_W-1:0] turn_wide;
   ulc_pkg::sat_type s_lin, s_turn, s_rx, s_ry;

   assign b4_ready = !b4_valid_ff || out_ready;
   assign b3_ready = !b3_valid_ff || b4_ready;
   assign b2_ready = !b2_valid_ff || b3_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign in_ready = b1_ready;

   assign b1_valid_in = in_valid;
   assign b2_valid_in = b1_valid_ff;
   assign b3_valid_in = b2_valid_ff;
   assign b4_valid_in = b3_valid_ff;

   // Stage 1: the four heading products
   always_comb begin
      b1_in.p_cv1  = in_word.cosine_val * in_word.v1;
      b1_in.p_sv2  = in_word.sine_val * in_word.v2;
      b1_in.p_cv2  = in_word.cosine_val * in_word.v2;
      b1_in.p_sv1  = in_word.sine_val * in_word.v1;
      b1_in.rate_x = in_word.rate_x;
      b1_in.rate_y = in_word.rate_y;
   end

   // Stage 2: rotate back to body frame, round by 14
   always_comb begin
      sum_lin      = ulc_pkg::TSUM_W'(b1_ff.p_cv1) + ulc_pkg::TSUM_W'(b1_ff.p_sv2);
      sum_turn     = ulc_pkg::TSUM_W'(b1_ff.p_cv2) - ulc_pkg::TSUM_W'(b1_ff.p_sv1);
      b2_in.lin    = rnd14(sum_lin);
      b2_in.t      = rnd14(sum_turn);
      b2_in.rate_x = b1_ff.rate_x;
      b2_in.rate_y = b1_ff.rate_y;
   end

   // Stage 3: scale the lateral term by 1/R
   always_comb begin
      recip_s      = signed'({1'b0, cfg.reciprocal_offset});
      b3_in.lin    = b2_ff.lin;
      b3_in.p_turn = b2_ff.t * recip_s;
      b3_in.rate_x = b2_ff.rate_x;
      b3_in.rate_y = b2_ff.rate_y;
   end

   // Stage 4: round and clip into the result word
   always_comb begin
      turn_wide          = rnd10(b3_ff.p_turn);
      s_lin              = ulc_pkg::sat16(ulc_pkg::SAT_IN_W'(b3_ff.lin));
      s_turn             = ulc_pkg::sat16(turn_wide);
      s_rx               = ulc_pkg::sat16(ulc_pkg::SAT_IN_W'(b3_ff.rate_x));
      s_ry               = ulc_pkg::sat16(ulc_pkg::SAT_IN_W'(b3_ff.rate_y));
      b4_in.linear_speed = s_lin.value;
      b4_in.turn_rate    = s_turn.value;
      b4_in.model_rate_x = s_rx.value;
      b4_in.model_rate_y = s_ry.value;
      b4_in.saturated    = s_lin.clip | s_turn.clip | s_rx.clip | s_ry.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         if (b1_ready) begin
            b1_valid_ff <= b1_valid_in;
         end
         if (b2_ready) begin
            b2_valid_ff <= b2_valid_in;
         end
         if (b3_ready) begin
            b3_valid_ff <= b3_valid_in;
         end
         if (b4_ready) begin
            b4_valid_ff <= b4_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b1_ready) begin
         b1_ff <= b1_in;
      end
      if (b2_ready) begin
         b2_ff <= b2_in;
      end
      if (b3_ready) begin
         b3_ff <= b3_in;
      end
      if (b4_ready) begin
         b4_ff <= b4_in;
      end
   end

   assign out_valid = b4_valid_ff;
   assign out_word  = b4_ff;

endmodule

### rtl/unicycle_linearizing_controller_unit.sv
// Unicycle feedback-linearizing controller, one control sample per word.
// Input channel: drive req_word and raise push; the word is taken on a clock
//   edge with push high and full low.
// Result channel: while empty is low, rsp_word holds the oldest result; it is
//   taken on an edge with pop high. A stalled result holds its value.
// Registers (APB, pready tied high, 32-bit data): 0x0 gain_x, 0x4 gain_y,
//   0x8 reciprocal_offset, each in bits [15:0]. Write only while idle.
// A word taken on an edge passes three front stages, one queue slot and
//   four back stages before it shows on rsp_word.
// Throughput: one word per cycle while pop keeps results moving, set by the
//   register after every multiply stage; nothing is iterated or shared.
// Front and back are split by a 4-word queue; the back stalls first when pop
//   is low, the queue then fills, then the front, and only then full rises.
// Reset (synchronous, active high) empties the pipeline and the queue and
//   loads the gains with 1.0 (Q4.12) and 1/R with 1.0 (Q6.10).
module unicycle_linearizing_controller_unit (
   input  logic                             clock,
   input  logic                             reset,
   // sample in
   input  logic                             push,
   output logic                             full,
   input  ulc_pkg::req_type                 req_word,
   // result out
   input  logic                             pop,
   output logic                             empty,
   output ulc_pkg::rsp_type                 rsp_word,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ulc_pkg::PADDR_W-1:0]      paddr,
   input  logic [ulc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ulc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   ulc_pkg::cfg_type cfg_in, cfg_ff;
   logic [ulc_pkg::REG_IDX_W-1:0] reg_idx;
   logic csr_write;

   logic             front_ready;
   logic             front_valid;
   ulc_pkg::mid_type front_word;
   logic             mq_full, mq_empty;
   ulc_pkg::mid_type mq_word;
   logic             back_ready;
   logic             back_valid;

   // ---------------- register file ----------------
   assign pready    = 1'b1;
   assign reg_idx   = paddr[ulc_pkg::PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            ulc_pkg::REG_GAIN_X:     cfg_in.gain_x            = pwdata[15:0];
            ulc_pkg::REG_GAIN_Y:     cfg_in.gain_y            = pwdata[15:0];
            ulc_pkg::REG_RECIP_OFFS: cfg_in.reciprocal_offset = pwdata[15:0];
            default:                 cfg_in = cfg_ff;   // unmapped, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_x            <= ulc_pkg::GAIN_RESET;
         cfg_ff.gain_y            <= ulc_pkg::GAIN_RESET;
         cfg_ff.reciprocal_offset <= ulc_pkg::RECIP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         ulc_pkg::REG_GAIN_X:     prdata = ulc_pkg::CSR_DATA_W'(cfg_ff.gain_x);
         ulc_pkg::REG_GAIN_Y:     prdata = ulc_pkg::CSR_DATA_W'(cfg_ff.gain_y);
         ulc_pkg::REG_RECIP_OFFS: prdata = ulc_pkg::CSR_DATA_W'(cfg_ff.reciprocal_offset);
         default:                 prdata = '0;
      endcase
   end

   // ---------------- front: differences, gains, sin/cos ----------------
   ulc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (front_ready),
      .in_word   (req_word),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_ready (!mq_full),
      .out_word  (front_word)
   );

   assign full = !front_ready;

   // ---------------- decoupling queue ----------------
   ulc_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .full      (mq_full),
      .push_word (front_word),
      .pop       (back_ready),
      .empty     (mq_empty),
      .pop_word  (mq_word)
   );

   // ---------------- back: inverse heading matrix, clip ----------------
   ulc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mq_empty),
      .in_ready  (back_ready),
      .in_word   (mq_word),
      .cfg       (cfg_ff),
      .out_valid (back_valid),
      .out_ready (pop),
      .out_word  (rsp_word)
   );

   assign empty = !back_valid;

endmodule

### rtl/ulc_checker.sv
module ulc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           full,
   input logic                           pop,
   input logic                           empty,
   input ulc_pkg::rsp_type               rsp_word,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [ulc_pkg::PADDR_W-1:0]    paddr,
   input logic [ulc_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [ulc_pkg::CSR_DATA_W-1:0] prdata,
   input logic                           pready
);

   logic gain_x_write, gain_x_read;

   assign gain_x_write = psel && penable && pwrite && pready &&
                         paddr[ulc_pkg::PADDR_W-1:2] == ulc_pkg::REG_GAIN_X;
   assign gain_x_read  = psel && !pwrite &&
                         paddr[ulc_pkg::PADDR_W-1:2] == ulc_pkg::REG_GAIN_X;

   // reset leaves nothing in flight and room for input
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not idle after reset");

   // input backs up only once a result is waiting
   a_full_has_result: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("full with no result waiting");

   // stalled result keeps its word
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("waiting result changed");

   // gain write is visible on the next read
   a_gain_readback: assert property (@(posedge clock) disable iff (reset)
      gain_x_write ##1 gain_x_read |-> prdata[15:0] == $past(pwdata[15:0]))
      else $error("gain_x readback mismatch");

endmodule

bind unicycle_linearizing_controller_unit ulc_checker u_checker (.*);
